### rtl/core/hsv_pixel_color_pipeline_unit_defines.svh
// ----------------------------------------------------------------------------
// HSV pixel color pipeline - assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef HSV_PIXEL_COLOR_PIPELINE_UNIT_DEFINES_SVH
`define HSV_PIXEL_COLOR_PIPELINE_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define HPC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hpc assertion failed");

// next-cycle implication, disabled during reset
`define HPC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hpc assertion failed");

// next-cycle implication that stays live through reset
`define HPC_ASSERT_RST(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("hpc assertion failed");

`endif

### rtl/core/hpc_pkg.sv
// ----------------------------------------------------------------------------
// hpc_pkg
// Types, constants and helpers shared by the HSV pixel color pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package hpc_pkg;

  localparam int unsigned CH_W            = 8;
  localparam int unsigned HUE_REGION_SIZE = 43;
  localparam int unsigned HUE_REGION_STEP = 6;
  localparam int unsigned CHANNEL_FULL    = 255;
  localparam int unsigned GRB_W           = 24;
  localparam int unsigned GREEN_LSB       = 16;
  localparam int unsigned RED_LSB         = 8;
  localparam int unsigned BRIGHT_RESET    = 128;
  localparam int unsigned APB_ADDR_W      = 3;
  localparam int unsigned APB_DATA_W      = 32;

  localparam logic OP_HSV = 1'b0;
  localparam logic OP_RGB = 1'b1;

  typedef logic [CH_W-1:0] chan_t;

  typedef enum logic [2:0] {
    REGION_0 = 3'd0,
    REGION_1 = 3'd1,
    REGION_2 = 3'd2,
    REGION_3 = 3'd3,
    REGION_4 = 3'd4,
    REGION_5 = 3'd5
  } hue_region_t;

  typedef struct packed {
    chan_t r;
    chan_t g;
    chan_t b;
  } pixel_t;

  typedef struct packed {
    hue_region_t region;
    chan_t       pos;
  } hue_split_t;

  // hue / 43 by compare chain, position scaled by 6 (max 252, no wrap)
  function automatic hue_split_t hue_split(input chan_t hue);
    hue_split_t res;
    chan_t      base;
    chan_t      offs;
    if (hue >= chan_t'(5*HUE_REGION_SIZE)) begin
      res.region = REGION_5;
      base = chan_t'(5*HUE_REGION_SIZE);
    end else if (hue >= chan_t'(4*HUE_REGION_SIZE)) begin
      res.region = REGION_4;
      base = chan_t'(4*HUE_REGION_SIZE);
    end else if (hue >= chan_t'(3*HUE_REGION_SIZE)) begin
      res.region = REGION_3;
      base = chan_t'(3*HUE_REGION_SIZE);
    end else if (hue >= chan_t'(2*HUE_REGION_SIZE)) begin
      res.region = REGION_2;
      base = chan_t'(2*HUE_REGION_SIZE);
    end else if (hue >= chan_t'(HUE_REGION_SIZE)) begin
      res.region = REGION_1;
      base = chan_t'(HUE_REGION_SIZE);
    end else begin
      res.region = REGION_0;
      base = '0;
    end
    offs = hue - base;
    res.pos = chan_t'(offs * HUE_REGION_STEP);
    return res;
  endfunction

  // (a * b) >> 8
  function automatic chan_t mul_hi(input chan_t a, input chan_t b);
    logic [2*CH_W-1:0] prod;
    prod = a * b;
    return prod[2*CH_W-1:CH_W];
  endfunction

endpackage

`default_nettype wire

### rtl/core/hpc_hsv.sv
// ----------------------------------------------------------------------------
// hpc_hsv
// Two-stage HSV to RGB conversion; RGB requests pass through unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module hpc_hsv import hpc_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire logic   in_op,
  input  wire chan_t  in_hue,
  input  wire chan_t  in_saturation,
  input  wire chan_t  in_value,
  input  wire pixel_t in_rgb,
  output logic        pix_valid,
  input  wire logic   pix_ready,
  output pixel_t      pix
);

  typedef struct packed {
    logic        op;
    logic        grey;
    hue_region_t region;
    chan_t       v;
    chan_t       p;
    chan_t       sp;
    chan_t       st;
    pixel_t      rgb;
  } stage_a_t;

  // stage A: region split and the first round of products
  logic       a_valid_r;
  logic       a_ready;
  logic       b_ready;
  stage_a_t   a_r;
  stage_a_t   a_nxt;
  hue_split_t split;

  assign a_ready = !a_valid_r || b_ready;
  assign in_ready = a_ready;

  always_comb begin
    split       = hue_split(in_hue);
    a_nxt.op    = in_op;
    a_nxt.grey  = (in_saturation == '0);
    a_nxt.region = split.region;
    a_nxt.v     = in_value;
    a_nxt.p     = mul_hi(in_value, chan_t'(CHANNEL_FULL) - in_saturation);
    a_nxt.sp    = mul_hi(in_saturation, split.pos);
    a_nxt.st    = mul_hi(in_saturation, chan_t'(CHANNEL_FULL) - split.pos);
    a_nxt.rgb   = in_rgb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_r <= a_nxt;
    end
  end

  // stage B: q and t, then channel selection by region
  logic   b_valid_r;
  pixel_t b_r;
  pixel_t b_nxt;
  chan_t  q;
  chan_t  t;

  assign b_ready = !b_valid_r || pix_ready;

  always_comb begin
    q = mul_hi(a_r.v, chan_t'(CHANNEL_FULL) - a_r.sp);
    t = mul_hi(a_r.v, chan_t'(CHANNEL_FULL) - a_r.st);
    case (a_r.region)
      REGION_0: b_nxt = '{r: a_r.v, g: t,     b: a_r.p};
      REGION_1: b_nxt = '{r: q,     g: a_r.v, b: a_r.p};
      REGION_2: b_nxt = '{r: a_r.p, g: a_r.v, b: t};
      REGION_3: b_nxt = '{r: a_r.p, g: q,     b: a_r.v};
      REGION_4: b_nxt = '{r: t,     g: a_r.p, b: a_r.v};
      default:  b_nxt = '{r: a_r.v, g: a_r.p, b: q};
    endcase
    if (a_r.grey) begin
      b_nxt = '{r: a_r.v, g: a_r.v, b: a_r.v};
    end
    if (a_r.op == OP_RGB) begin
      b_nxt = a_r.rgb;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_ready) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid_r) begin
      b_r <= b_nxt;
    end
  end

  assign pix_valid = b_valid_r;
  assign pix       = b_r;

endmodule

`default_nettype wire

### rtl/core/hpc_scale.sv
// ----------------------------------------------------------------------------
// hpc_scale
// Two-stage brightness scaling (channel * brightness / 255) and GRB packing.
// ----------------------------------------------------------------------------
`default_nettype none

module hpc_scale import hpc_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire chan_t  brightness,
  input  wire logic   pix_valid,
  output logic        pix_ready,
  input  wire pixel_t pix,
  output logic        out_valid,
  input  wire logic   out_ready,
  output logic [GRB_W-1:0] out_grb_word
);

  localparam int unsigned PROD_W = 2*CH_W;

  typedef logic [PROD_W-1:0] prod_t;

  // x / 255 for x <= 255*255: (x + 1 + (x >> 8)) >> 8
  function automatic chan_t div255(input prod_t x);
    prod_t sum;
    sum = x + prod_t'(1) + prod_t'(x[PROD_W-1:CH_W]);
    return sum[PROD_W-1:CH_W];
  endfunction

  // stage C: products
  logic  c_valid_r;
  logic  c_ready;
  logic  d_ready;
  prod_t c_r_r;
  prod_t c_g_r;
  prod_t c_b_r;

  assign c_ready   = !c_valid_r || d_ready;
  assign pix_ready = c_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (c_ready) begin
      c_valid_r <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && pix_valid) begin
      c_r_r <= pix.r * brightness;
      c_g_r <= pix.g * brightness;
      c_b_r <= pix.b * brightness;
    end
  end

  // stage D: divide and pack, output register
  logic             d_valid_r;
  logic [GRB_W-1:0] d_word_r;
  logic [GRB_W-1:0] d_word_nxt;

  assign d_ready = !d_valid_r || out_ready;

  always_comb begin
    d_word_nxt = '0;
    d_word_nxt[GREEN_LSB +: CH_W] = div255(c_g_r);
    d_word_nxt[RED_LSB +: CH_W]   = div255(c_r_r);
    d_word_nxt[CH_W-1:0]          = div255(c_b_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (d_ready) begin
      d_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready && c_valid_r) begin
      d_word_r <= d_word_nxt;
    end
  end

  assign out_valid    = d_valid_r;
  assign out_grb_word = d_word_r;

endmodule

`default_nettype wire

### rtl/core/hsv_pixel_color_pipeline_unit.sv
// A four-stage pixel pipeline: one pixel per cycle sustained while out_ready
// holds. Stage one splits hue into six regions and forms the first products,
// stage two forms q and t and picks the channels, stage three multiplies each
// channel by brightness, stage four divides by 255 and holds the packed GRB
// word. Ready runs back through the four stage registers, so a stalled output
// fills the stages before in_ready drops. brightness resets to 128 and sits at
// APB byte address 0.
// ----------------------------------------------------------------------------
// hsv_pixel_color_pipeline_unit
// HSV/RGB pixel to brightness-scaled GRB word for an LED strip.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_pixel_color_pipeline_unit import hpc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  // pixel requests
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_op,
  input  wire logic [CH_W-1:0]       in_hue,
  input  wire logic [CH_W-1:0]       in_saturation,
  input  wire logic [CH_W-1:0]       in_value,
  input  wire logic [CH_W-1:0]       in_red,
  input  wire logic [CH_W-1:0]       in_green,
  input  wire logic [CH_W-1:0]       in_blue,
  // results
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [GRB_W-1:0]           out_grb_word
);

  // register 0 decodes on the word index bit only
  logic  bright_sel;
  chan_t brightness_r;

  assign pready     = 1'b1;
  assign bright_sel = (paddr[APB_ADDR_W-1] == 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= chan_t'(BRIGHT_RESET);
    end else if (psel && penable && pwrite && pready && bright_sel) begin
      brightness_r <= pwdata[CH_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (bright_sel) begin
      prdata[CH_W-1:0] = brightness_r;
    end
  end

  pixel_t in_rgb;
  pixel_t pix;
  logic   pix_valid;
  logic   pix_ready;

  assign in_rgb = '{r: in_red, g: in_green, b: in_blue};

  hpc_hsv u_hsv (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_hue       (in_hue),
    .in_saturation(in_saturation),
    .in_value     (in_value),
    .in_rgb       (in_rgb),
    .pix_valid    (pix_valid),
    .pix_ready    (pix_ready),
    .pix          (pix)
  );

  hpc_scale u_scale (
    .clk         (clk),
    .rst_n       (rst_n),
    .brightness  (brightness_r),
    .pix_valid   (pix_valid),
    .pix_ready   (pix_ready),
    .pix         (pix),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_grb_word(out_grb_word)
  );

endmodule

`default_nettype wire

### rtl/core/hpc_checker.sv
// ----------------------------------------------------------------------------
// hpc_checker
// Port-level checks on the pixel pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hsv_pixel_color_pipeline_unit_defines.svh"

module hpc_checker import hpc_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [GRB_W-1:0] out_grb_word
);

  // a stalled result holds
  `HPC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_grb_word))

  // an empty output stage or a ready sink means the pipeline can take a request
  `HPC_ASSERT_IMP(a_ready_when_drained, clk, rst_n, !out_valid || out_ready, in_ready)

  // nothing is left in flight after reset
  `HPC_ASSERT_RST(a_reset_flush, clk, !rst_n, !out_valid)

  // with the output empty and no request offered, the pipeline stays ready
  `HPC_ASSERT_NXT(a_no_spurious, clk, rst_n, !out_valid && !in_valid && in_ready, in_ready)

endmodule

bind hsv_pixel_color_pipeline_unit hpc_checker u_hpc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_grb_word(out_grb_word)
);

`default_nettype wire
